>>> hdl/lcc_pkg.sv
// lcc_pkg: shared constants, types and the offset rounding function
// used by the luminance/contrast block and its offset channel unit
// no dependencies
package lcc_pkg;

  localparam int CHAN_BITS   = 8;
  localparam int CHAN_NUM    = 1 << CHAN_BITS;
  localparam int FACTOR_BITS = 10;
  localparam int CFG_W       = 17;
  localparam int IN_TDATA_W  = 40;

  // luminance fraction bits and result packing
  localparam int LUMA_FRAC_BITS = 16;
  localparam int LUM_W          = LUMA_FRAC_BITS + 1;
  localparam int OUT_BITS       = LUM_W + 4 * CHAN_BITS;
  localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CHAN_BITS-1:0] CHAN_MAX         = 8'd255;
  localparam logic [CHAN_BITS-1:0] DARK_LEVEL       = 8'd10;
  localparam logic [CHAN_BITS-1:0] DARK_SOFT_LEVEL  = 8'd30;
  localparam logic [CHAN_BITS-1:0] LIGHT_SOFT_LEVEL = 8'd200;

  // srgb curve constants, scaled to integers
  localparam longint unsigned LIN_KNEE = 64'd3928 * 64'd255;
  localparam longint unsigned LIN_DEN  = 64'd1292 * 64'd255;
  localparam longint unsigned POW_DEN  = 64'd1055 * 64'd255;
  localparam longint unsigned Q30_ONE  = 64'd1 << 30;

  // luminance weights, sum divided by LUM_DIV
  localparam int unsigned W_RED   = 2126;
  localparam int unsigned W_GREEN = 7152;
  localparam int unsigned W_BLUE  = 722;
  localparam int unsigned LUM_DIV = 10000;
  localparam int unsigned LUM_RND = 5000;

  // scaled threshold: lum > t  <=>  sum >= (t + 1) * LUM_DIV
  localparam int THR_W = 31;
  localparam int unsigned BRIGHT_THRESH_RST = 26214;
  localparam logic [THR_W-1:0] THR_RST = THR_W'((BRIGHT_THRESH_RST + 1) * LUM_DIV);

  localparam int OFF_W = 21;

  typedef struct packed {
    logic [CHAN_BITS-1:0] to_dark;
    logic [CHAN_BITS-1:0] to_light;
  } off_pair_t;

  function automatic logic [CHAN_BITS-1:0] round_sat(input logic signed [OFF_W-1:0] n);
    logic signed [OFF_W-1:0] s;
    logic [CHAN_BITS-1:0]    res;
    s = (n + OFF_W'(128)) >>> 8;
    if (n <= 0) begin
      res = '0;
    end else if (s > $signed(OFF_W'(CHAN_MAX))) begin
      res = CHAN_MAX;
    end else begin
      res = s[CHAN_BITS-1:0];
    end
    return res;
  endfunction

endpackage

>>> hdl/luminance_contrast_color.sv
// luminance_contrast_color: top level, three register stages
// srgb lookup rom, weighted luminance sum, threshold, contrast and offset colour
// depends on lcc_pkg and lcc_offset
//
// One beat per clock on each side while no result is held back. Stage one registers
// the beat, stage two reads the three srgb lookup rom entries (256 entries, built at
// elaboration) and forms the weighted sum and both offset colours, stage three
// divides the sum by 10000 through a reciprocal multiply, applies the threshold and
// registers the result. All stages advance together: in_tready is low only while a
// result waits and out_tready is low.
module luminance_contrast_color
  import lcc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // red_in, green_in, blue_in, offset_factor, zero pad
  input  logic [IN_TDATA_W-1:0]     in_tdata,
  // softer
  input  logic                      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // luminance_out, contrast_level, offset_red, offset_green, offset_blue, zero pad
  output logic [OUT_TDATA_W-1:0]    out_tdata,
  // is_bright
  output logic                      out_tuser
);

  localparam int LIN_W       = LUMA_FRAC_BITS + 1;
  localparam int RND_SH      = 30 - LUMA_FRAC_BITS;
  localparam int SUM_W       = LUMA_FRAC_BITS + 14;
  localparam int Q_W         = SUM_W - 4;
  localparam int D_K         = Q_W + 10;
  localparam int RECIP_W     = D_K - 9;
  localparam int PROD_W      = Q_W + RECIP_W;
  localparam int CMP_W       = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam longint unsigned RECIP = ((64'd1 << D_K) + 64'd624) / 64'd625;
  localparam logic [LUM_W-1:0] LUM_ONE = LUM_W'(1) << LUMA_FRAC_BITS;

  typedef logic [LIN_W-1:0] lin_rom_t [CHAN_NUM];

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t          rom;
    longint unsigned   t;
    longint unsigned   u;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   mid;
    longint unsigned   p;
    longint unsigned   w;
    longint unsigned   num;
    longint unsigned   vv;
    for (int v = 0; v < CHAN_NUM; v++) begin
      vv = longint'(v);
      if (vv * 64'd100000 <= LIN_KNEE) begin
        num = (vv * 64'd100) << LUMA_FRAC_BITS;
        rom[v] = LIN_W'((num + LIN_DEN / 2) / LIN_DEN);
      end else begin
        t = ((64'd1000 * vv + 64'd55 * 64'd255) << 30) / POW_DEN;
        if (t > Q30_ONE) begin
          t = Q30_ONE;
        end
        u  = (t * t) >> 30;
        lo = 0;
        hi = Q30_ONE;
        while (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          p = mid;
          for (int k = 0; k < 4; k++) begin
            p = (p * mid) >> 30;
          end
          if (p <= u) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        w = (u * lo) >> 30;
        rom[v] = LIN_W'((w + (64'd1 << (RND_SH - 1))) >> RND_SH);
      end
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

  logic                        en;
  logic [THR_W-1:0]            thr_r;
  logic [THR_W-1:0]            thr_nxt;

  logic                        s1_valid_r;
  logic [CHAN_BITS-1:0]        s1_red_r;
  logic [CHAN_BITS-1:0]        s1_green_r;
  logic [CHAN_BITS-1:0]        s1_blue_r;
  logic signed [FACTOR_BITS-1:0] s1_factor_r;
  logic                        s1_soft_r;

  logic [SUM_W-1:0]            sum_nxt;
  off_pair_t                   off_red;
  off_pair_t                   off_green;
  off_pair_t                   off_blue;

  logic                        s2_valid_r;
  logic [SUM_W-1:0]            s2_sum_r;
  off_pair_t                   s2_red_r;
  off_pair_t                   s2_green_r;
  off_pair_t                   s2_blue_r;
  logic                        s2_soft_r;

  logic [PROD_W-1:0]           prod;
  logic                        bright_nxt;
  logic [CHAN_BITS-1:0]        level_nxt;

  logic                        out_valid_r;
  logic                        out_bright_r;
  logic [LUM_W-1:0]            out_lum_r;
  logic [CHAN_BITS-1:0]        out_level_r;
  logic [CHAN_BITS-1:0]        out_red_r;
  logic [CHAN_BITS-1:0]        out_green_r;
  logic [CHAN_BITS-1:0]        out_blue_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign thr_nxt = (THR_W'(cfg_wdata) + THR_W'(1)) * THR_W'(LUM_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
    end else if (cfg_we) begin
      thr_r <= thr_nxt;
    end
  end

  // stage one: input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_red_r    <= in_tdata[7:0];
      s1_green_r  <= in_tdata[15:8];
      s1_blue_r   <= in_tdata[23:16];
      s1_factor_r <= $signed(in_tdata[33:24]);
      s1_soft_r   <= in_tuser;
    end
  end

  // stage two: linearize, weighted sum, offset colours
  assign sum_nxt = SUM_W'(LIN_ROM[s1_red_r])   * SUM_W'(W_RED)
                 + SUM_W'(LIN_ROM[s1_green_r]) * SUM_W'(W_GREEN)
                 + SUM_W'(LIN_ROM[s1_blue_r])  * SUM_W'(W_BLUE)
                 + SUM_W'(LUM_RND);

  lcc_offset u_off_red (
    .chan   (s1_red_r),
    .factor (s1_factor_r),
    .res    (off_red)
  );

  lcc_offset u_off_green (
    .chan   (s1_green_r),
    .factor (s1_factor_r),
    .res    (off_green)
  );

  lcc_offset u_off_blue (
    .chan   (s1_blue_r),
    .factor (s1_factor_r),
    .res    (off_blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum_r   <= sum_nxt;
      s2_red_r   <= off_red;
      s2_green_r <= off_green;
      s2_blue_r  <= off_blue;
      s2_soft_r  <= s1_soft_r;
    end
  end

  // stage three: divide by 10000 as (sum >> 4) / 625, threshold, select
  assign prod       = PROD_W'(s2_sum_r[SUM_W-1:4]) * PROD_W'(RECIP);
  assign bright_nxt = CMP_W'(s2_sum_r) >= CMP_W'(thr_r);

  always_comb begin
    if (bright_nxt) begin
      level_nxt = s2_soft_r ? DARK_SOFT_LEVEL : DARK_LEVEL;
    end else begin
      level_nxt = s2_soft_r ? LIGHT_SOFT_LEVEL : CHAN_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bright_r <= bright_nxt;
      out_lum_r    <= prod[D_K +: LUM_W];
      out_level_r  <= level_nxt;
      out_red_r    <= bright_nxt ? s2_red_r.to_dark   : s2_red_r.to_light;
      out_green_r  <= bright_nxt ? s2_green_r.to_dark : s2_green_r.to_light;
      out_blue_r   <= bright_nxt ? s2_blue_r.to_dark  : s2_blue_r.to_light;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_bright_r;
  assign out_tdata  = OUT_TDATA_W'({out_blue_r, out_green_r, out_red_r, out_level_r,
                                    out_lum_r});

  a_beat_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && en |=> out_valid_r)
    else $error("stage two beat lost");

  a_dark_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bright_r |-> (out_level_r == DARK_LEVEL ||
                                     out_level_r == DARK_SOFT_LEVEL))
    else $error("bright beat with light contrast level");

  a_light_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bright_r |-> (out_level_r == CHAN_MAX ||
                                      out_level_r == LIGHT_SOFT_LEVEL))
    else $error("dark beat with dark contrast level");

  a_lum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_lum_r <= LUM_ONE)
    else $error("luminance above one");

  a_bright_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bright_r |-> out_lum_r != '0)
    else $error("bright beat with zero luminance");

endmodule

>>> hdl/lcc_offset.sv
// lcc_offset: one channel of the offset colour, both directions
// computes the pull toward black and toward white, rounded and saturated
// depends on lcc_pkg
module lcc_offset
  import lcc_pkg::*;
(
  input  logic [CHAN_BITS-1:0]          chan,
  input  logic signed [FACTOR_BITS-1:0] factor,
  output off_pair_t                     res
);

  logic signed [OFF_W-1:0] c_s;
  logic signed [OFF_W-1:0] inv_s;
  logic signed [OFF_W-1:0] f_s;
  logic signed [OFF_W-1:0] keep_s;
  logic signed [OFF_W-1:0] n_dark;
  logic signed [OFF_W-1:0] n_light;

  assign c_s    = OFF_W'($signed({1'b0, chan}));
  assign inv_s  = OFF_W'($signed({1'b0, CHAN_MAX - chan}));
  assign f_s    = OFF_W'(factor);
  assign keep_s = OFF_W'(256) - f_s;

  assign n_dark  = c_s * keep_s;
  assign n_light = (c_s <<< 8) + inv_s * f_s;

  assign res.to_dark  = round_sat(n_dark);
  assign res.to_light = round_sat(n_light);

endmodule

>>> tb/tb_luminance_contrast_color.sv
// tb_luminance_contrast_color: self-checking testbench for luminance_contrast_color
// a scoreboard class predicts luminance, contrast level and offset colour per input beat
// depends on lcc_pkg and the luminance_contrast_color rtl
`timescale 1ns / 1ps

module tb_luminance_contrast_color
  import lcc_pkg::*;
();

  localparam int OUT_W       = 56;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 215;
  localparam int HOLD_CYCLES = 64;

  typedef struct packed {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [9:0] factor;
    bit       softer;
  } color_req_t;

  typedef struct packed {
    bit        bright;
    bit [16:0] lum;
    bit [7:0]  level;
    bit [7:0]  off_red;
    bit [7:0]  off_green;
    bit [7:0]  off_blue;
  } color_res_t;

  class lum_scoreboard;
    bit [16:0]  lin_rom[256];
    bit [16:0]  threshold;
    color_res_t expected_q[$];
    int         errors;

    function new();
      longint unsigned vv, t, u, lo, hi, mid, p, w, den;
      den = 1292 * 255;
      for (int v = 0; v < 256; v++) begin
        vv = v;
        if (100000 * vv <= 3928 * 255) begin
          lin_rom[v] = 17'((((vv * 100) << 16) + den / 2) / den);
        end else begin
          t = ((1000 * vv + 55 * 255) << 30) / (1055 * 255);
          if (t > (64'd1 << 30)) t = 64'd1 << 30;
          u = (t * t) >> 30;
          lo = 0;
          hi = 64'd1 << 30;
          // largest fifth root with truncating q30 multiplies
          while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            p = mid;
            repeat (4) p = (p * mid) >> 30;
            if (p <= u) lo = mid;
            else hi = mid - 1;
          end
          w = (u * lo) >> 30;
          lin_rom[v] = 17'((w + (64'd1 << 13)) >> 14);
        end
      end
      threshold = 17'(BRIGHT_THRESH_RST);
      errors = 0;
    endfunction

    function bit [16:0] luma(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      longint unsigned sum;
      sum = longint'(W_RED) * lin_rom[r] + longint'(W_GREEN) * lin_rom[g]
          + longint'(W_BLUE) * lin_rom[b] + LUM_RND;
      return 17'(sum / LUM_DIV);
    endfunction

    function bit [7:0] offset_level(bit [7:0] c, int f, bit bright);
      longint cc, ff, n;
      cc = c;
      ff = f;
      if (bright) n = 256 * cc - cc * ff;
      else n = 256 * cc + (255 - cc) * ff;
      if (n <= 0) return 8'd0;
      n = (n + 128) >>> 8;
      if (n > 255) n = 255;
      return n[7:0];
    endfunction

    function void note_color(color_req_t c);
      color_res_t res;
      int f;
      f = $signed(c.factor);
      res.lum = luma(c.red, c.green, c.blue);
      res.bright = res.lum > threshold;
      if (res.bright) res.level = c.softer ? DARK_SOFT_LEVEL : DARK_LEVEL;
      else res.level = c.softer ? LIGHT_SOFT_LEVEL : CHAN_MAX;
      res.off_red = offset_level(c.red, f, res.bright);
      res.off_green = offset_level(c.green, f, res.bright);
      res.off_blue = offset_level(c.blue, f, res.bright);
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(color_res_t got);
      color_res_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no pending input");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("is_bright", want.bright, got.bright);
      compare_field("luminance_out", want.lum, got.lum);
      compare_field("contrast_level", want.level, got.level);
      compare_field("offset_red", want.off_red, got.off_red);
      compare_field("offset_green", want.off_green, got.off_green);
      compare_field("offset_blue", want.off_blue, got.off_blue);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_tvalid;
  logic             in_tready;
  // red_in, green_in, blue_in, offset_factor, zero pad
  logic [IN_TDATA_W-1:0] in_tdata;
  // softer
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // luminance_out, contrast_level, offset_red, offset_green, offset_blue, zero pad
  logic [OUT_W-1:0] out_tdata;
  // is_bright
  logic             out_tuser;

  lum_scoreboard sb;
  color_res_t    got;
  color_req_t    anchor;
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;
  int            hold_left = 0;
  int unsigned   cycle_count = 0;

  luminance_contrast_color u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("luminance_contrast_color: mismatch");
      $finish;
    end
  end

  // result side: check accepted beats, random backpressure, long hold on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.bright = out_tuser;
      got.lum = out_tdata[16:0];
      got.level = out_tdata[24:17];
      got.off_red = out_tdata[32:25];
      got.off_green = out_tdata[40:33];
      got.off_blue = out_tdata[48:41];
      sb.check_result(got);
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 33);
    end
  end

  task automatic drive_color(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [9:0] f, bit s);
    color_req_t c;
    c = '{red: r, green: g, blue: b, factor: f, softer: s};
    while (!calm && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, c.factor, c.blue, c.green, c.red};
    in_tuser <= c.softer;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_color(c);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(bit [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.threshold = v;
  endtask

  function automatic bit [7:0] pick_channel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd10 + 8'($urandom_range(1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic bit [9:0] pick_factor();
    case ($urandom_range(9))
      0: return 10'h200;
      1: return 10'h1FF;
      2: return 10'h000;
      3: return 10'h100;
      4: return 10'h300;
      default: return 10'($urandom);
    endcase
  endfunction

  initial begin
    bit [CFG_W-1:0] thr;
    bit [7:0] r, g, b;
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, the linear/power knee, greys around the reset threshold
    drive_color(8'd0, 8'd0, 8'd0, 10'h000, 1'b0);
    drive_color(8'd255, 8'd255, 8'd255, 10'h000, 1'b0);
    drive_color(8'd255, 8'd255, 8'd255, 10'h1FF, 1'b1);
    drive_color(8'd0, 8'd0, 8'd0, 10'h200, 1'b1);
    drive_color(8'd10, 8'd10, 8'd10, 10'h100, 1'b0);
    drive_color(8'd11, 8'd11, 8'd11, 10'h100, 1'b1);
    drive_color(8'd10, 8'd0, 8'd0, 10'h080, 1'b0);
    drive_color(8'd0, 8'd11, 8'd0, 10'h080, 1'b0);
    drive_color(8'd0, 8'd0, 8'd11, 10'h080, 1'b1);
    drive_color(8'd169, 8'd169, 8'd169, 10'h040, 1'b0);
    drive_color(8'd170, 8'd170, 8'd170, 10'h040, 1'b1);
    drive_color(8'd171, 8'd171, 8'd171, 10'h3C0, 1'b0);
    drive_color(8'd255, 8'd0, 8'd0, 10'h300, 1'b0);
    drive_color(8'd0, 8'd255, 8'd0, 10'h080, 1'b1);
    drive_color(8'd0, 8'd0, 8'd255, 10'h1FF, 1'b0);
    drive_color(8'd128, 8'd64, 8'd32, 10'h3FF, 1'b1);
    drive_color(8'd200, 8'd100, 8'd50, 10'h201, 1'b0);
    drive_color(8'd255, 8'd255, 8'd255, 10'h200, 1'b0);
    drive_color(8'd1, 8'd254, 8'd1, 10'h200, 1'b1);

    anchor = '{red: 8'd170, green: 8'd170, blue: 8'd170, factor: 10'h0, softer: 1'b0};
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        anchor = '{red: 8'($urandom), green: 8'($urandom), blue: 8'($urandom),
                   factor: 10'h0, softer: 1'b0};
        case (p)
          1: thr = 17'd0;
          2: thr = 17'h1FFFF;
          3: thr = 17'd65536;
          4: thr = 17'd65535;
          5: thr = 17'd1;
          default: thr = sb.luma(anchor.red, anchor.green, anchor.blue);
        endcase
        write_threshold(thr);
      end
      calm = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 100) hold_req = 1'b1;
        if (p == 5 && i == 100) wait_idle();
        case ($urandom_range(9))
          0: begin
            r = anchor.red;
            g = anchor.green;
            b = anchor.blue;
          end
          1: begin
            r = anchor.red + 8'($urandom_range(2)) - 8'd1;
            g = anchor.green + 8'($urandom_range(2)) - 8'd1;
            b = anchor.blue + 8'($urandom_range(2)) - 8'd1;
          end
          default: begin
            r = pick_channel();
            g = pick_channel();
            b = pick_channel();
          end
        endcase
        drive_color(r, g, b, pick_factor(), 1'($urandom));
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("luminance_contrast_color: match");
    end else begin
      $display("luminance_contrast_color: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/lcc_pkg.sv
hdl/lcc_offset.sv
hdl/luminance_contrast_color.sv
tb/tb_luminance_contrast_color.sv
